### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

### rtl/otq_pkg.sv
// Types and constants of the ordered timer queue.
package otq_pkg;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 4;
  localparam int TIME_W = 64;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd2;

  typedef struct packed {
    logic              fired_valid;
    logic [SLOT_W-1:0] fired_slot;
    logic              last;
  } result_t;

endpackage

### rtl/otq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module otq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/otq_ctrl.sv
// Sequencer, slot scan with shared compare unit, and shared deadline adder.
module otq_ctrl #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [otq_pkg::CMD_W-1:0]         command,
  input  logic [otq_pkg::SLOT_W-1:0]        timer_slot,
  input  logic [otq_pkg::TIME_W-1:0]        timeout,
  input  logic [otq_pkg::TIME_W-1:0]        repeat_period,
  input  logic [otq_pkg::TIME_W-1:0]        now,
  input  logic                              out_free,
  output logic                              ready,
  output logic                              push_en,
  output otq_pkg::result_t                  push,
  output logic                              dl_we,
  output logic [$clog2(TIMER_SLOTS)-1:0]    dl_waddr,
  output logic [otq_pkg::TIME_W-1:0]        dl_wdata,
  output logic [$clog2(TIMER_SLOTS)-1:0]    dl_raddr,
  input  logic [otq_pkg::TIME_W-1:0]        dl_rdata,
  output logic                              pr_we,
  output logic [$clog2(TIMER_SLOTS)-1:0]    pr_waddr,
  output logic [otq_pkg::TIME_W-1:0]        pr_wdata,
  output logic [$clog2(TIMER_SLOTS)-1:0]    pr_raddr,
  input  logic [otq_pkg::TIME_W-1:0]        pr_rdata
);
  import otq_pkg::*;

  localparam int SW = $clog2(TIMER_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(TIMER_SLOTS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FIRE   = 3'd4;
  localparam logic [2:0] ST_REARM  = 3'd5;
  localparam logic [2:0] ST_FINAL  = 3'd6;

  logic [2:0]             state;
  logic [TIMER_SLOTS-1:0] armed;
  logic [TIMER_SLOTS-1:0] done;
  logic [SW-1:0]          cnt;
  logic                   rd_v;
  logic [SW-1:0]          rd_i;
  logic                   best_found;
  logic [TIME_W-1:0]      best_dl;
  logic [SW-1:0]          best_idx;
  logic                   pend_valid;
  logic [SW-1:0]          pend_slot;
  logic [TIME_W-1:0]      now_q;

  logic                   in_range;
  logic [SW-1:0]          slot_idx;
  logic                   start_wr;
  logic [TIME_W-1:0]      add_a;
  logic [TIME_W-1:0]      add_b;
  logic                   cand;
  logic                   better;

  assign in_range = int'(timer_slot) < TIMER_SLOTS;
  assign slot_idx = SW'(timer_slot);
  assign start_wr = accept && (command == CMD_START) && in_range;

  // one adder: now+timeout on start, now+period on re-arm
  assign add_a    = (state == ST_IDLE) ? now : now_q;
  assign add_b    = (state == ST_IDLE) ? timeout : pr_rdata;
  assign dl_wdata = add_a + add_b;
  assign dl_waddr = (state == ST_IDLE) ? slot_idx : best_idx;
  assign dl_we    = start_wr || ((state == ST_REARM) && (pr_rdata != '0));
  assign dl_raddr = cnt;

  assign pr_we    = start_wr;
  assign pr_waddr = slot_idx;
  assign pr_wdata = repeat_period;
  assign pr_raddr = best_idx;

  // compare unit: expired, and earlier than the best so far (ties keep lower slot)
  assign cand   = rd_v && armed[rd_i] && !done[rd_i] && (dl_rdata <= now_q);
  assign better = !best_found || (dl_rdata < best_dl);

  assign ready = (state == ST_IDLE);

  assign push_en = ((state == ST_DECIDE) && best_found && pend_valid && out_free) ||
                   ((state == ST_FINAL) && out_free);
  assign push.fired_valid = pend_valid;
  assign push.fired_slot  = pend_valid ? SLOT_W'(pend_slot) : '0;
  assign push.last        = (state == ST_FINAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      armed      <= '0;
      rd_v       <= 1'b0;
      best_found <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      rd_v <= (state == ST_SCAN);
      rd_i <= cnt;
      if (cand && better) begin
        best_found <= 1'b1;
        best_dl    <= dl_rdata;
        best_idx   <= rd_i;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              CMD_START: begin
                if (in_range) begin
                  armed[slot_idx] <= 1'b1;
                end
              end
              CMD_STOP: begin
                if (in_range) begin
                  armed[slot_idx] <= 1'b0;
                end
              end
              CMD_PROCESS: begin
                now_q      <= now;
                done       <= '0;
                cnt        <= '0;
                best_found <= 1'b0;
                state      <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          cnt <= cnt + SW'(1);
          if (cnt == LAST_IDX) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!best_found) begin
            state <= ST_FINAL;
          end else if (!pend_valid || out_free) begin
            pend_valid <= 1'b1;
            pend_slot  <= best_idx;
            state      <= ST_FIRE;
          end
        end
        ST_FIRE: begin
          state <= ST_REARM;
        end
        ST_REARM: begin
          done[best_idx] <= 1'b1;
          if (pr_rdata == '0) begin
            armed[best_idx] <= 1'b0;
          end
          cnt        <= '0;
          best_found <= 1'b0;
          state      <= ST_SCAN;
        end
        ST_FINAL: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ordered_timer_queue.sv
// Ordered timer queue: top level with slot stores and output register.
//
// Commands arrive on the s_ stream, one per transfer. Start arms a slot with
// deadline now+timeout and a repeat period, stop disarms it, process fires
// every expired slot, earliest deadline first, ties to the lower slot.
// Results leave on the m_ stream, only for process: one transfer per fired
// slot (m_tuser high), or a single transfer with m_tuser low when nothing
// expired; m_tlast marks the final result of a process command.
// Start and stop are taken in the idle state. Process scans the slots one
// per cycle through the single read port of the deadline RAM: each fired
// slot costs a full scan, and a final scan that finds nothing left comes
// before the closing result. s_tready is low while a process command runs.
// Reset disarms every slot; deadline and period stores are not cleared.
// A stalled receiver holds the output register; the scan for the next
// slot still runs, and the block waits only when a further result is due.
`include "assert_macros.svh"

module ordered_timer_queue #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // command[1:0], timer_slot[5:2], timeout[69:6], repeat_period[133:70],
  // now[197:134], zero pad
  input  logic [otq_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // fired_slot[3:0], zero pad
  output logic [otq_pkg::OUT_DATA_W-1:0]   m_tdata,
  // fired_valid[0]
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import otq_pkg::*;

  localparam int SW = $clog2(TIMER_SLOTS);

  logic              accept;
  logic              out_free;
  logic              push_en;
  result_t           push;
  result_t           res;
  logic              dl_we;
  logic [SW-1:0]     dl_waddr;
  logic [TIME_W-1:0] dl_wdata;
  logic [SW-1:0]     dl_raddr;
  logic [TIME_W-1:0] dl_rdata;
  logic              pr_we;
  logic [SW-1:0]     pr_waddr;
  logic [TIME_W-1:0] pr_wdata;
  logic [SW-1:0]     pr_raddr;
  logic [TIME_W-1:0] pr_rdata;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  otq_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (s_tdata[1:0]),
    .timer_slot    (s_tdata[5:2]),
    .timeout       (s_tdata[69:6]),
    .repeat_period (s_tdata[133:70]),
    .now           (s_tdata[197:134]),
    .out_free      (out_free),
    .ready         (s_tready),
    .push_en       (push_en),
    .push          (push),
    .dl_we         (dl_we),
    .dl_waddr      (dl_waddr),
    .dl_wdata      (dl_wdata),
    .dl_raddr      (dl_raddr),
    .dl_rdata      (dl_rdata),
    .pr_we         (pr_we),
    .pr_waddr      (pr_waddr),
    .pr_wdata      (pr_wdata),
    .pr_raddr      (pr_raddr),
    .pr_rdata      (pr_rdata)
  );

  otq_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TIMER_SLOTS)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  otq_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TIMER_SLOTS)
  ) u_period_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_en) begin
      m_tvalid <= 1'b1;
      res      <= push;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - SLOT_W){1'b0}}, res.fired_slot};
  assign m_tuser = res.fired_valid;
  assign m_tlast = res.last;

  // a result is only loaded into a free output register
  `ASSERT_NEVER(a_no_overwrite, clk, rst, push_en && !out_free)
  // an empty result always closes the process command
  `ASSERT_NEVER(a_empty_is_last, clk, rst, m_tvalid && !m_tuser && !m_tlast)
  // a result that is not the last one means the process command is still running
  `ASSERT_NEVER(a_busy_mid_burst, clk, rst, m_tvalid && !m_tlast && s_tready)
  // results are only produced while a command is being worked on
  `ASSERT_PROP(a_push_busy, clk, rst, push_en |-> !s_tready)

endmodule
